/* rtl/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mmpb_pkg.sv */
// ----------------------------------------------------------------------------
// mmpb_pkg
// Types and fixed field widths of the mip pyramid box filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmpb_pkg;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 32;
   localparam int LEVEL_W    = 4;
   localparam int XY_W       = 11;
   localparam int CFG_W      = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } rgb_type;

endpackage

/* rtl/mmpb_if.sv */
// ----------------------------------------------------------------------------
// mmpb_req_if / mmpb_rsp_if
// Valid/ready channels for base pixel beats and level pixel beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mmpb_req_if import mmpb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface mmpb_rsp_if import mmpb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic [XY_W-1:0]    out_x;
   logic [XY_W-1:0]    out_y;
   logic [SUM_W-1:0]   red_sum;
   logic [SUM_W-1:0]   green_sum;
   logic [SUM_W-1:0]   blue_sum;
   logic               last;

   modport source (output valid, level, out_x, out_y, red_sum, green_sum, blue_sum, last,
                   input ready);
   modport sink (input valid, level, out_x, out_y, red_sum, green_sum, blue_sum, last,
                 output ready);
endinterface

/* rtl/mipmap_pyramid_box_filter.sv */
// ----------------------------------------------------------------------------
// mipmap_pyramid_box_filter
// Flow: an accepted pixel beat passes ST_LVL and ST_ADD before any level beat it
//    yields is registered; a new pixel is taken only in ST_IDLE, once the last is done;
//    a stalled level beat holds the shared adder.
// Reset: synchronous; 4096x4096, position 0,0; pair and row stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mipmap_pyramid_box_filter import mmpb_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_LEVELS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   mmpb_req_if.sink              req_if,
   mmpb_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int DW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int OW = CW + 2;
   localparam int PI = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LVL  = 3'b010,
      ST_ADD  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   width_cfg_ff, width_cfg_in;
   logic [CFG_W-1:0]   height_cfg_ff, height_cfg_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      b_ff, b_in;
   logic [RW-1:0]      a_ff, a_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [OW-1:0]      off_ff, off_in;
   logic [DW-1:0]      w_ff, w_in;
   logic [LEVEL_W-1:0] levels_ff, levels_in;
   rgb_type            cur_ff, cur_in;
   rgb_type            sum_ff, sum_in;
   rgb_type            pend_ff [MAX_LEVELS];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [XY_W-1:0]    rsp_x_ff;
   logic [XY_W-1:0]    rsp_y_ff;
   rgb_type            rsp_sum_ff;
   logic               rsp_last_ff;

   logic [DW-1:0]      wc;
   logic [HW-1:0]      hc;
   logic [LEVEL_W-1:0] lv;
   logic               req_fire;
   logic               csr_wr;
   logic [DW-1:0]      col_inc;
   logic [HW-1:0]      row_inc;

   logic [CW-1:0]      p;
   logic [RW-1:0]      a_half;
   logic [OW-1:0]      idx;
   logic               idx_ok;
   logic [LEVEL_W-1:0] lvl_next;
   logic [OW-1:0]      off_next;
   logic [OW-1:0]      more_idx;
   logic               more;
   logic               add_go;
   logic               pend_we;
   logic [31:0]        x_ext;
   logic [31:0]        y_ext;

   rgb_type            op_a, op_b, total;
   logic               ram_we, ram_re;
   logic [$bits(rgb_type)-1:0] ram_rd_data;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      csr_prdata    = '0;
      unique case (reg_index_type'(csr_paddr[2]))
         REG_IMAGE_WIDTH: begin
            csr_prdata = CSR_DATA_W'(width_cfg_ff);
            if (csr_wr) begin
               width_cfg_in = csr_pwdata[CFG_W-1:0];
            end
         end
         REG_IMAGE_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(height_cfg_ff);
            if (csr_wr) begin
               height_cfg_in = csr_pwdata[CFG_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // clamped dimensions and level count
   always_comb begin
      if (width_cfg_ff == '0) begin
         wc = DW'(1);
      end else if (32'(width_cfg_ff) > 32'(MAX_WIDTH)) begin
         wc = DW'(MAX_WIDTH);
      end else begin
         wc = DW'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         hc = HW'(1);
      end else if (32'(height_cfg_ff) > 32'(MAX_HEIGHT)) begin
         hc = HW'(MAX_HEIGHT);
      end else begin
         hc = HW'(height_cfg_ff);
      end
      lv = LEVEL_W'(1);
      for (int k = 1; k < MAX_LEVELS; k++) begin
         if (((32'(wc) >> k) > 32'd1) && ((32'(hc) >> k) > 32'd1)) begin
            lv = lv + LEVEL_W'(1);
         end
      end
   end

   // level step datapath
   assign req_fire = req_if.valid && (state_ff == ST_IDLE);
   assign req_if.ready = (state_ff == ST_IDLE);

   assign col_inc  = DW'(col_ff) + DW'(1);
   assign row_inc  = HW'(row_ff) + HW'(1);
   assign p        = b_ff >> 1;
   assign a_half   = a_ff >> 1;
   assign idx      = off_ff + OW'(p);
   assign idx_ok   = 32'(idx) < 32'(MAX_WIDTH);
   assign lvl_next = lvl_ff + LEVEL_W'(1);
   assign off_next = off_ff + OW'(w_ff >> lvl_next);
   assign more_idx = off_next + OW'(p >> 1);
   assign more     = (lvl_next < levels_ff) && p[0] && a_half[0] &&
                     (32'(more_idx) < 32'(MAX_WIDTH));
   assign add_go   = !rsp_valid_ff || rsp_if.ready;
   assign x_ext    = 32'(p);
   assign y_ext    = 32'(a_half);

   assign op_a = (state_ff == ST_ADD) ? rgb_type'(ram_rd_data) : pend_ff[lvl_ff[PI-1:0]];
   assign op_b = (state_ff == ST_ADD) ? sum_ff : cur_ff;

   mmpb_sum_unit u_sum (
      .op_a  (op_a),
      .op_b  (op_b),
      .total (total)
   );

   assign pend_we = (state_ff == ST_LVL) && !b_ff[0];
   assign ram_we  = (state_ff == ST_LVL) && b_ff[0] && idx_ok && !a_ff[0];
   assign ram_re  = (state_ff == ST_LVL) && b_ff[0] && idx_ok && a_ff[0];

   mmpb_ram #(
      .WIDTH ($bits(rgb_type)),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx[CW-1:0]),
      .wr_data (total),
      .rd_en   (ram_re),
      .rd_addr (idx[CW-1:0]),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      b_in         = b_ff;
      a_in         = a_ff;
      lvl_in       = lvl_ff;
      off_in       = off_ff;
      w_in         = w_ff;
      levels_in    = levels_ff;
      cur_in       = cur_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               b_in         = col_ff;
               a_in         = row_ff;
               lvl_in       = '0;
               off_in       = '0;
               w_in         = wc;
               levels_in    = lv;
               cur_in.red   = SUM_W'(req_if.red);
               cur_in.green = SUM_W'(req_if.green);
               cur_in.blue  = SUM_W'(req_if.blue);
               state_in     = ST_LVL;
               if (col_inc >= wc) begin
                  col_in = '0;
                  row_in = (row_inc >= hc) ? '0 : row_inc[RW-1:0];
               end else begin
                  col_in = col_inc[CW-1:0];
               end
            end
         end
         ST_LVL: begin
            sum_in   = total;
            state_in = (b_ff[0] && idx_ok && a_ff[0]) ? ST_ADD : ST_IDLE;
         end
         ST_ADD: begin
            if (add_go) begin
               rsp_valid_in = 1'b1;
               cur_in       = total;
               lvl_in       = lvl_next;
               a_in         = a_half;
               b_in         = p;
               off_in       = off_next;
               state_in     = (lvl_next < levels_ff) ? ST_LVL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_cfg_ff  <= DIM_RESET;
         height_cfg_ff <= DIM_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff      <= b_in;
      a_ff      <= a_in;
      lvl_ff    <= lvl_in;
      off_ff    <= off_in;
      w_ff      <= w_in;
      levels_ff <= levels_in;
      cur_ff    <= cur_in;
      sum_ff    <= sum_in;
      if (pend_we) begin
         pend_ff[lvl_ff[PI-1:0]] <= cur_ff;
      end
      if ((state_ff == ST_ADD) && add_go) begin
         rsp_level_ff <= lvl_next;
         rsp_x_ff     <= x_ext[XY_W-1:0];
         rsp_y_ff     <= y_ext[XY_W-1:0];
         rsp_sum_ff   <= total;
         rsp_last_ff  <= !more;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.level     = rsp_level_ff;
   assign rsp_if.out_x     = rsp_x_ff;
   assign rsp_if.out_y     = rsp_y_ff;
   assign rsp_if.red_sum   = rsp_sum_ff.red;
   assign rsp_if.green_sum = rsp_sum_ff.green;
   assign rsp_if.blue_sum  = rsp_sum_ff.blue;
   assign rsp_if.last      = rsp_last_ff;

endmodule

/* rtl/mmpb_ram.sv */
// ----------------------------------------------------------------------------
// mmpb_ram
// Generic simple dual port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmpb_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mmpb_sum_unit.sv */
// ----------------------------------------------------------------------------
// mmpb_sum_unit
// Shared three-lane 32-bit adder for the pair and block sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmpb_sum_unit import mmpb_pkg::*; (
   input  rgb_type op_a,
   input  rgb_type op_b,
   output rgb_type total
);

   // sums wrap modulo 2^32
   assign total.red   = op_a.red + op_b.red;
   assign total.green = op_a.green + op_b.green;
   assign total.blue  = op_a.blue + op_b.blue;

endmodule

/* rtl/mmpb_checker.sv */
// ----------------------------------------------------------------------------
// mmpb_checker
// Port-level checks on the mip pyramid box filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmpb_checker import mmpb_pkg::*; #(
   parameter int MAX_LEVELS = 12
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LEVEL_W-1:0] rsp_level,
   input logic [XY_W-1:0]    rsp_out_x,
   input logic [XY_W-1:0]    rsp_out_y,
   input logic [SUM_W-1:0]   rsp_red_sum,
   input logic [SUM_W-1:0]   rsp_green_sum,
   input logic [SUM_W-1:0]   rsp_blue_sum,
   input logic               rsp_last
);

   logic                                req_fire;
   logic                                rsp_stall;
   logic                                level_ok;
   logic [LEVEL_W+2*XY_W+3*SUM_W+1:0] rsp_beat;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign level_ok  = (rsp_level != '0) && (32'(rsp_level) <= 32'(MAX_LEVELS));
   // valid is part of the held beat
   assign rsp_beat  = {rsp_valid, rsp_level, rsp_out_x, rsp_out_y, rsp_red_sum,
                       rsp_green_sum, rsp_blue_sum, rsp_last};

   `ASSERT_CLK(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp valid after reset")

   `ASSERT_CLK_RST(a_busy_after_accept, clock, reset, req_fire |=> !req_ready, "still ready")

   `ASSERT_CLK_RST(a_level_range, clock, reset, rsp_valid |-> level_ok, "rsp level out of range")

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_beat), "rsp beat changed")

endmodule

bind mipmap_pyramid_box_filter mmpb_checker #(
   .MAX_LEVELS (MAX_LEVELS)
) u_mmpb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_level     (rsp_if.level),
   .rsp_out_x     (rsp_if.out_x),
   .rsp_out_y     (rsp_if.out_y),
   .rsp_red_sum   (rsp_if.red_sum),
   .rsp_green_sum (rsp_if.green_sum),
   .rsp_blue_sum  (rsp_if.blue_sum),
   .rsp_last      (rsp_if.last)
);
